FILE: sv/lprl_pkg.sv
// Shared types and constants for the longest prefix route lookup block.
`timescale 1ns / 1ps
`default_nettype none
package lprl_pkg;

  localparam int IDX_FIELD_W  = 4;
  localparam int PORT_FIELD_W = 4;
  localparam int ADDR_W       = 32;
  localparam int IN_TDATA_W   = 144;
  localparam int OUT_TDATA_W  = 72;

  // Request kinds carried on the input tuser bit.
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  // One classified request as it travels from the front end to the back end.
  typedef struct packed {
    logic                    is_lookup;
    logic                    write_ok;
    logic [IDX_FIELD_W-1:0]  idx;
    logic                    live;
    logic [ADDR_W-1:0]       prefix;
    logic [ADDR_W-1:0]       mask;
    logic [PORT_FIELD_W-1:0] port;
    logic [ADDR_W-1:0]       gateway;
    logic [ADDR_W-1:0]       addr;
  } cmd_t;

  // Payload of one route table slot.
  typedef struct packed {
    logic [ADDR_W-1:0]       prefix;
    logic [ADDR_W-1:0]       mask;
    logic [PORT_FIELD_W-1:0] port;
    logic [ADDR_W-1:0]       gateway;
  } ent_t;

  // One result word.
  typedef struct packed {
    logic                    found;
    logic [IDX_FIELD_W-1:0]  idx;
    logic [PORT_FIELD_W-1:0] port;
    logic [ADDR_W-1:0]       gateway;
    logic [ADDR_W-1:0]       mask;
  } res_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_WAIT,
    BK_FIN
  } bk_state_t;

endpackage
`default_nettype wire

FILE: sv/longest_prefix_route_lookup.sv
// Top level of the longest prefix route lookup block.
//
// The block holds a table of IPv4 routes and answers lookups against it.
// Input words arrive on the in_ stream. in_tuser selects the request: a write
// loads or clears one table slot, a lookup searches for the live route whose
// masked prefix equals the masked address and whose mask is the largest,
// the lowest slot winning a tie. Every input word yields exactly one output
// word on the out_ stream; a write answers with an all-zero word.
// A front end registers and range-checks each word and hands it through a
// two-word queue to a back end, so new words are taken while the back end
// is busy or the output is stalled. A write needs no scan. A lookup reads
// the route memory one slot per cycle through its single read port, so
// it occupies the back end until every slot has been read and compared.
// Reset clears the live bit of every slot, so the table starts empty; route
// payloads are not cleared and need no clearing pass. When the receiver holds
// out_tready low, the result word stays in the output register, the back end
// waits, and the queue fills until in_tready drops.
`timescale 1ns / 1ps
`default_nettype none
module longest_prefix_route_lookup #(
  parameter int TABLE_ENTRIES = 16,
  parameter int PORT_COUNT    = 16
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  // Fields from bit 0: entry_index[3:0], entry_valid[4], entry_prefix[36:5],
  // entry_mask[68:37], entry_port[72:69], entry_gateway[104:73],
  // lookup_address[136:105], zero fill up to bit 143.
  input  wire  [lprl_pkg::IN_TDATA_W-1:0]    in_tdata,
  // req_type: 0 writes a slot, 1 looks up an address.
  input  wire                                in_tuser,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  // Fields from bit 0: match_index[3:0], match_port[7:4],
  // match_gateway[39:8], match_mask[71:40].
  output logic [lprl_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // match_found.
  output logic                               out_tuser
);

  lprl_pkg::cmd_t front_cmd;
  logic           front_valid;
  logic           front_ready;
  lprl_pkg::cmd_t back_cmd;
  logic           back_valid;
  logic           back_ready;
  lprl_pkg::res_t res;

  lprl_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .PORT_COUNT    (PORT_COUNT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  lprl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_cmd    (back_cmd)
  );

  lprl_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .cmd       (back_cmd),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  // Pack the result word, first field in the lowest bits.
  assign out_tdata = {res.mask, res.gateway, res.port, res.idx};
  assign out_tuser = res.found;

endmodule
`default_nettype wire

FILE: sv/lprl_front.sv
// Front end: takes input words, unpacks and range-checks them into commands.
`timescale 1ns / 1ps
`default_nettype none
module lprl_front #(
  parameter int TABLE_ENTRIES = 16,
  parameter int PORT_COUNT    = 16
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire  [lprl_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  wire                              in_tuser,
  output logic                             cmd_valid,
  input  wire                              cmd_ready,
  output lprl_pkg::cmd_t                   cmd
);

  logic           slot_valid_r;
  logic           slot_valid_nxt;
  lprl_pkg::cmd_t slot_r;
  lprl_pkg::cmd_t slot_nxt;
  logic           accept;

  assign in_tready = !slot_valid_r || cmd_ready;
  assign accept    = in_tvalid && in_tready;
  assign cmd_valid = slot_valid_r;
  assign cmd       = slot_r;

  always_comb begin
    slot_nxt.is_lookup = (in_tuser == lprl_pkg::REQ_LOOKUP);
    slot_nxt.idx       = in_tdata[3:0];
    slot_nxt.live      = in_tdata[4];
    slot_nxt.prefix    = in_tdata[36:5];
    slot_nxt.mask      = in_tdata[68:37];
    slot_nxt.port      = in_tdata[72:69];
    slot_nxt.gateway   = in_tdata[104:73];
    slot_nxt.addr      = in_tdata[136:105];
    // A write to a slot or port beyond the configured sizes is dropped.
    slot_nxt.write_ok  = ({28'd0, in_tdata[3:0]} < 32'(TABLE_ENTRIES)) &&
                         ({28'd0, in_tdata[72:69]} < 32'(PORT_COUNT));
    if (accept) begin
      slot_valid_nxt = 1'b1;
    end else if (cmd_ready) begin
      slot_valid_nxt = 1'b0;
    end else begin
      slot_valid_nxt = slot_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= 1'b0;
    end else begin
      slot_valid_r <= slot_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot_r <= slot_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: sv/lprl_queue.sv
// Two-entry command queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module lprl_queue (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             push_valid,
  output logic            push_ready,
  input  lprl_pkg::cmd_t  push_cmd,
  output logic            pop_valid,
  input  wire             pop_ready,
  output lprl_pkg::cmd_t  pop_cmd
);

  lprl_pkg::cmd_t q_r [2];
  logic           wr_ptr_r;
  logic           wr_ptr_nxt;
  logic           rd_ptr_r;
  logic           rd_ptr_nxt;
  logic [1:0]     count_r;
  logic [1:0]     count_nxt;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_cmd    = q_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

FILE: sv/lprl_back.sv
// Back end: route table storage, sequential longest-prefix search and result register.
`timescale 1ns / 1ps
`default_nettype none
module lprl_back #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             cmd_valid,
  output logic            cmd_ready,
  input  lprl_pkg::cmd_t  cmd,
  output logic            res_valid,
  input  wire             res_ready,
  output lprl_pkg::res_t  res
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int EXT_W = IDX_W + lprl_pkg::IDX_FIELD_W;
  localparam logic [IDX_W-1:0] CNT_LAST = IDX_W'(TABLE_ENTRIES - 1);

  lprl_pkg::ent_t      mem [TABLE_ENTRIES];
  logic                live_r [TABLE_ENTRIES];

  lprl_pkg::bk_state_t state_r, state_nxt;
  logic [IDX_W-1:0]    cnt_r, cnt_nxt;
  logic [31:0]         addr_r, addr_nxt;

  logic                rd_en;
  logic                rd_v_r;
  logic                rd_live_r;
  logic [IDX_W-1:0]    rd_idx_r;
  lprl_pkg::ent_t      rd_ent_r;

  logic                best_found_r, best_found_nxt;
  logic [IDX_W-1:0]    best_idx_r, best_idx_nxt;
  lprl_pkg::ent_t      best_ent_r, best_ent_nxt;

  logic                out_valid_r, out_valid_nxt;
  lprl_pkg::res_t      out_r, out_nxt;

  logic                out_free;
  logic                mem_we;
  logic                clear_best;
  logic                hit;
  logic [EXT_W-1:0]    wr_ext;
  logic [EXT_W-1:0]    best_ext;
  lprl_pkg::ent_t      wr_ent;

  assign out_free  = !out_valid_r || res_ready;
  assign res_valid = out_valid_r;
  assign res       = out_r;
  assign wr_ext    = EXT_W'(cmd.idx);
  assign best_ext  = EXT_W'(best_idx_r);

  always_comb begin
    wr_ent.prefix  = cmd.prefix;
    wr_ent.mask    = cmd.mask;
    wr_ent.port    = cmd.port;
    wr_ent.gateway = cmd.gateway;
  end

  // Sequencer for table writes and the slot-by-slot search.
  always_comb begin
    state_nxt     = state_r;
    cmd_ready     = 1'b0;
    mem_we        = 1'b0;
    rd_en         = 1'b0;
    clear_best    = 1'b0;
    cnt_nxt       = cnt_r;
    addr_nxt      = addr_r;
    out_valid_nxt = out_valid_r && !res_ready;
    out_nxt       = out_r;
    case (state_r)
      lprl_pkg::BK_IDLE: begin
        if (cmd_valid) begin
          if (cmd.is_lookup) begin
            cmd_ready  = 1'b1;
            addr_nxt   = cmd.addr;
            cnt_nxt    = '0;
            clear_best = 1'b1;
            state_nxt  = lprl_pkg::BK_SCAN;
          end else if (out_free) begin
            cmd_ready     = 1'b1;
            mem_we        = cmd.write_ok;
            out_valid_nxt = 1'b1;
            out_nxt       = '0;
          end
        end
      end
      lprl_pkg::BK_SCAN: begin
        rd_en   = 1'b1;
        cnt_nxt = cnt_r + IDX_W'(1);
        if (cnt_r == CNT_LAST) begin
          state_nxt = lprl_pkg::BK_WAIT;
        end
      end
      lprl_pkg::BK_WAIT: begin
        state_nxt = lprl_pkg::BK_FIN;
      end
      lprl_pkg::BK_FIN: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_nxt.found   = best_found_r;
          out_nxt.idx     = best_ext[lprl_pkg::IDX_FIELD_W-1:0];
          out_nxt.port    = best_ent_r.port;
          out_nxt.gateway = best_ent_r.gateway;
          out_nxt.mask    = best_ent_r.mask;
          state_nxt       = lprl_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = lprl_pkg::BK_IDLE;
      end
    endcase
  end

  // Compare the slot read last cycle against the running best.
  // A larger mask value wins; on a tie the earlier slot stays.
  always_comb begin
    hit = rd_v_r && rd_live_r &&
          ((rd_ent_r.prefix & rd_ent_r.mask) == (addr_r & rd_ent_r.mask)) &&
          (!best_found_r || (rd_ent_r.mask > best_ent_r.mask));
    best_found_nxt = best_found_r;
    best_idx_nxt   = best_idx_r;
    best_ent_nxt   = best_ent_r;
    if (clear_best) begin
      best_found_nxt = 1'b0;
      best_idx_nxt   = '0;
      best_ent_nxt   = '0;
    end else if (hit) begin
      best_found_nxt = 1'b1;
      best_idx_nxt   = rd_idx_r;
      best_ent_nxt   = rd_ent_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lprl_pkg::BK_IDLE;
      out_valid_r  <= 1'b0;
      rd_v_r       <= 1'b0;
      best_found_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      rd_v_r       <= rd_en;
      best_found_r <= best_found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    addr_r     <= addr_nxt;
    out_r      <= out_nxt;
    best_idx_r <= best_idx_nxt;
    best_ent_r <= best_ent_nxt;
  end

  // Live bits, cleared at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        live_r[i] <= 1'b0;
      end
    end else if (mem_we) begin
      live_r[wr_ext[IDX_W-1:0]] <= cmd.live;
    end
  end

  // Route payload memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_ext[IDX_W-1:0]] <= wr_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_ent_r  <= mem[cnt_r];
      rd_live_r <= live_r[cnt_r];
      rd_idx_r  <= cnt_r;
    end
  end

endmodule
`default_nettype wire
